// ===== hdl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// types, character codes and helpers shared by the hex record parser files
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

  localparam int OUT_TDATA_W = 80;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  localparam logic       KIND_DATA    = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic [9:0] IDX_MAX = 10'd1023;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_HEADER,
    PH_DATA,
    PH_SEGMENT,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_value;
    logic [31:0] image_offset;
    logic        start_found;
    logic [31:0] start_address;
    logic        last;
  } result_t;

  // results made by one character, first in order then second
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // bit 4 set when the character is a hex digit, low bits its value
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ihex_parse_core.sv =====
// ----------------------------------------------------------------------------
// ihex_parse_core
// per-character record state machine; yields up to two results per character
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_parse_core import ihex_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_text,
  output push_t           push
);

  phase_t      phase, phase_next;
  logic [9:0]  char_index, char_index_next;
  logic [7:0]  rec_len, rec_len_next;
  logic [15:0] rec_off, rec_off_next;
  logic [7:0]  rec_kind, rec_kind_next;
  logic [4:0]  pend, pend_next;
  logic [15:0] upper_base, upper_base_next;
  logic [15:0] seg_accum, seg_accum_next;
  logic        seg_bad, seg_bad_next;
  logic [31:0] first_address, first_address_next;
  logic [31:0] image_count, image_count_next;
  logic        parse_ended, parse_ended_next;
  logic        have_start, have_start_next;

  logic [4:0]  hv;
  logic [9:0]  k;
  logic        byte_out;
  logic [7:0]  byte_val;
  result_t     data_res, sum_res;

  always_comb begin
    hv = hex_of(char_code);
    k  = char_index - 10'd9;
    phase_next         = phase;
    char_index_next    = char_index;
    rec_len_next       = rec_len;
    rec_off_next       = rec_off;
    rec_kind_next      = rec_kind;
    pend_next          = pend;
    upper_base_next    = upper_base;
    seg_accum_next     = seg_accum;
    seg_bad_next       = seg_bad;
    first_address_next = first_address;
    image_count_next   = image_count;
    parse_ended_next   = parse_ended;
    have_start_next    = have_start;
    byte_out           = 1'b0;
    byte_val           = {pend[3:0], hv[3:0]};

    if (!parse_ended) begin
      if (char_code == CHAR_LF) begin
        if (phase == PH_SEGMENT) begin
          upper_base_next = (!seg_bad && char_index >= 10'd13) ? seg_accum : 16'd0;
        end
        phase_next      = PH_LINE_START;
        char_index_next = 10'd0;
        rec_len_next    = 8'd0;
        rec_off_next    = 16'd0;
        rec_kind_next   = 8'd0;
        pend_next       = 5'd0;
        seg_accum_next  = 16'd0;
        seg_bad_next    = 1'b0;
      end else begin
        unique case (phase)
          PH_LINE_START: begin
            if (char_code == CHAR_SPACE || char_code == CHAR_TAB || char_code == CHAR_CR) begin
              phase_next = PH_LINE_START;
            end else if (char_code == CHAR_COLON) begin
              phase_next      = PH_HEADER;
              char_index_next = 10'd1;
            end else begin
              phase_next = PH_SKIP;
            end
          end
          PH_HEADER: begin
            if (!hv[4]) begin
              phase_next = PH_SKIP;
            end else begin
              if (char_index <= 10'd2) begin
                rec_len_next = {rec_len[3:0], hv[3:0]};
              end else if (char_index <= 10'd6) begin
                rec_off_next = {rec_off[11:0], hv[3:0]};
              end else begin
                rec_kind_next = {rec_kind[3:0], hv[3:0]};
              end
              char_index_next = 10'(char_index + 10'd1);
              if (char_index == 10'd2 && rec_len_next == 8'd0) begin
                phase_next = PH_SKIP;
              end else if (char_index >= 10'd8) begin
                if (rec_kind_next == REC_DATA) begin
                  if (!have_start) begin
                    have_start_next    = 1'b1;
                    first_address_next = {upper_base, 16'd0} + {16'd0, rec_off};
                  end
                  phase_next = PH_DATA;
                  pend_next  = 5'd0;
                end else if (rec_kind_next == REC_EXT_LIN) begin
                  if (rec_len == 8'd2) begin
                    phase_next     = PH_SEGMENT;
                    seg_accum_next = 16'd0;
                    seg_bad_next   = 1'b0;
                  end else begin
                    phase_next = PH_SKIP;
                  end
                end else if (rec_kind_next == REC_EOF) begin
                  parse_ended_next = 1'b1;
                  phase_next       = PH_SKIP;
                end else begin
                  phase_next = PH_SKIP;
                end
              end
            end
          end
          PH_DATA: begin
            if (char_index < IDX_MAX) begin
              char_index_next = 10'(char_index + 10'd1);
              if (k[9:1] < {1'b0, rec_len}) begin
                if (!k[0]) begin
                  pend_next = hv[4] ? hv : 5'd0;
                end else begin
                  if (pend[4] && hv[4]) begin
                    byte_out         = 1'b1;
                    image_count_next = 32'(image_count + 32'd1);
                  end
                  pend_next = 5'd0;
                end
              end
            end
          end
          PH_SEGMENT: begin
            if (char_index <= 10'd12) begin
              if (hv[4]) begin
                seg_accum_next = {seg_accum[11:0], hv[3:0]};
              end else begin
                seg_bad_next = 1'b1;
              end
              char_index_next = 10'(char_index + 10'd1);
            end
          end
          PH_SKIP: begin
            phase_next = PH_SKIP;
          end
          default: begin
            phase_next = PH_SKIP;
          end
        endcase
      end
    end

    data_res.kind          = KIND_DATA;
    data_res.data_value    = byte_val;
    data_res.image_offset  = image_count;
    data_res.start_found   = have_start;
    data_res.start_address = have_start ? first_address : 32'd0;
    data_res.last          = !end_of_text;

    sum_res.kind          = KIND_SUMMARY;
    sum_res.data_value    = 8'd0;
    sum_res.image_offset  = image_count_next;
    sum_res.start_found   = have_start_next;
    sum_res.start_address = have_start_next ? first_address_next : 32'd0;
    sum_res.last          = 1'b1;

    push.second = sum_res;
    if (!fire) begin
      push.count = 2'd0;
      push.first = data_res;
    end else if (byte_out) begin
      push.count = end_of_text ? 2'd2 : 2'd1;
      push.first = data_res;
    end else begin
      push.count = end_of_text ? 2'd1 : 2'd0;
      push.first = sum_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && end_of_text)) begin
      phase         <= PH_LINE_START;
      char_index    <= 10'd0;
      rec_len       <= 8'd0;
      rec_off       <= 16'd0;
      rec_kind      <= 8'd0;
      pend          <= 5'd0;
      upper_base    <= 16'd0;
      seg_accum     <= 16'd0;
      seg_bad       <= 1'b0;
      first_address <= 32'hFFFF_FFFF;
      image_count   <= 32'd0;
      parse_ended   <= 1'b0;
      have_start    <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      char_index    <= char_index_next;
      rec_len       <= rec_len_next;
      rec_off       <= rec_off_next;
      rec_kind      <= rec_kind_next;
      pend          <= pend_next;
      upper_base    <= upper_base_next;
      seg_accum     <= seg_accum_next;
      seg_bad       <= seg_bad_next;
      first_address <= first_address_next;
      image_count   <= image_count_next;
      parse_ended   <= parse_ended_next;
      have_start    <= have_start_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ihex_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ihex_out_fifo
// small result queue taking up to two results per cycle, giving one per beat
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_out_fifo import ihex_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_res
);

  result_t              entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_AW:0]     count, count_next;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = entries[rd_ptr];
  assign room      = (count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  always_comb begin
    count_next = count + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[FIFO_AW'(wr_ptr + 1'b1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= FIFO_AW'(wr_ptr + FIFO_AW'(push.count));
      rd_ptr <= FIFO_AW'(rd_ptr + FIFO_AW'(pop));
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/intel_hex_record_parser_top.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_parser_top
// hex record text parser: one character per beat in, data bytes and summary out
// ----------------------------------------------------------------------------
// Takes one character per cycle. A character is held in an input register,
// decoded by the record state machine once the output queue has room, and its
// results are written to a four-entry output queue, from which they are
// offered on the output. A character that ends the text after completing a
// data byte yields two results; the output side drains one result per beat,
// and the input stalls only while the queue holds more than two results.
// The summary beat carries tlast; data beats carry tlast when they are the
// only result of their character.
`default_nettype none

module intel_hex_record_parser_top import ihex_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,  // char_code
  input  wire logic                   s_axis_tlast,  // end_of_text
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // data_value, image_offset, start_found, start_address, zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tuser,  // result_kind
  output logic                        m_axis_tlast   // last_result
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_eot;
  logic       room;
  logic       fire;
  push_t      push;
  result_t    out_res;

  assign fire          = in_valid && room;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
      in_eot  <= s_axis_tlast;
    end
  end

  ihex_parse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .char_code   (in_char),
    .end_of_text (in_eot),
    .push        (push)
  );

  ihex_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.start_address, out_res.start_found,
                         out_res.image_offset, out_res.data_value};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire
